/* rtl/assert_macros.svh */
// Assertion macros shared by the bitmap allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked property with reset disable.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition that must never be true at a clock edge.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

/* rtl/bia_pkg.sv */
// Shared widths and codes for the bitmap identifier allocator.
package bia_pkg;

    localparam int ACTION_W = 3;
    localparam int INDEX_W  = 10;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;

    localparam logic [COUNT_W-1:0] NUM_BITS_RESET = 11'd1024;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TEST      = 3'd0,
        ACT_SET       = 3'd1,
        ACT_CLEAR     = 3'd2,
        ACT_FIND      = 3'd3,
        ACT_CLEAR_ALL = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

endpackage

/* rtl/bia_req_if.sv */
// Request channel: action and bit index with valid/ready.
interface bia_req_if;
    import bia_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  bit_index;

    modport source (output valid, output action, output bit_index, input ready);
    modport sink   (input valid, input action, input bit_index, output ready);
endinterface

/* rtl/bia_rsp_if.sv */
// Response channel: status, test bit and found index with valid/ready.
interface bia_rsp_if;
    import bia_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                bit_is_set;
    logic [INDEX_W-1:0]  found_index;

    modport source (output valid, output status, output bit_is_set, output found_index,
                    input ready);
    modport sink   (input valid, input status, input bit_is_set, input found_index,
                    output ready);
endinterface

/* rtl/bitmap_id_allocator.sv */
// Bitmap identifier allocator: test/set/clear/find-first-zero over a word RAM.
//
//  channel   dir   handshake      word contents
//  req       in    valid/ready    action, bit_index
//  rsp       out   valid/ready    status, bit_is_set, found_index
//  cfg       in    cfg_wr_en      cfg_wr_data -> num_bits
//
// Test, set and clear of an in-range index go from accept to the next accept
// through word read, modify/write-back, result into the output reg.
// Clear-all and rejected words never touch the RAM and go straight to finish.
// Find scans w words, w at most ceil(min(num_bits, MAX_BITS)/WORD_BITS),
// 32 at the defaults; the single RAM read port scans one word per cycle.
// Reset clears per-word valid flags at once, so no clearing pass is needed;
// clear-all does the same flag clear when it is accepted.
// A response waiting in the output register does not block the next accept;
// the block only holds in its finish state until that register frees up.
// WORD_BITS must be a power of two.
`include "assert_macros.svh"

module bitmap_id_allocator #(
    parameter int MAX_BITS  = 1024,
    parameter int WORD_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    bia_req_if.sink                     req,
    bia_rsp_if.source                   rsp,
    input  logic                        cfg_wr_en,
    input  logic [bia_pkg::COUNT_W-1:0] cfg_wr_data
);
    import bia_pkg::*;

    localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int POS_W     = WADDR_W + BIT_W;
    localparam int NWORDS_W  = COUNT_W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [ACTION_W-1:0]    action_reg, action_next;
    logic [INDEX_W-1:0]     idx_reg, idx_next;
    logic [WADDR_W-1:0]     scan_addr_reg, scan_addr_next;
    logic [NUM_WORDS-1:0]   word_valid_reg, word_valid_next;
    logic [COUNT_W-1:0]     num_bits_reg, num_bits_next;

    // pending result, waiting for the output register
    status_t                res_status_reg, res_status_next;
    logic                   res_is_set_reg, res_is_set_next;
    logic [INDEX_W-1:0]     res_found_reg, res_found_next;

    // output register
    logic                   rsp_valid_reg, rsp_valid_next;
    status_t                rsp_status_reg, rsp_status_next;
    logic                   rsp_is_set_reg, rsp_is_set_next;
    logic [INDEX_W-1:0]     rsp_found_reg, rsp_found_next;

    // RAM port
    logic                   ram_we, ram_re;
    logic [WADDR_W-1:0]     ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0]   ram_wdata, ram_rdata;

    logic [COUNT_W-1:0]     count;
    logic [NWORDS_W-1:0]    nwords;
    logic [INDEX_W-1:0]     req_word_sh, idx_word_sh;
    logic [WADDR_W-1:0]     look_addr, sel_addr;
    logic [WORD_BITS-1:0]   rd_word, bit_mask;
    logic [BIT_W-1:0]       zero_pos;
    logic [POS_W-1:0]       scan_pos;
    logic                   req_idx_ok;

    // lowest clear bit of a word (caller checks the word is not all ones)
    function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] k;
        k = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                k = BIT_W'(i);
            end
        end
        return k;
    endfunction

    bia_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // count saturates at MAX_BITS
    always_comb
    begin
        if (32'(num_bits_reg) > MAX_BITS)
        begin
            count = COUNT_W'(MAX_BITS);
        end
        else
        begin
            count = num_bits_reg;
        end
    end

    assign nwords      = (NWORDS_W'(count) + NWORDS_W'(WORD_BITS - 1)) >> BIT_W;
    assign req_word_sh = req.bit_index >> BIT_W;
    assign idx_word_sh = idx_reg >> BIT_W;
    assign look_addr   = WADDR_W'(idx_word_sh);
    assign req_idx_ok  = {1'b0, req.bit_index} < count;

    // never-written or cleared words read as zero
    assign sel_addr = (state_reg == S_SCAN) ? scan_addr_reg : look_addr;
    assign rd_word  = ram_rdata & {WORD_BITS{word_valid_reg[sel_addr]}};
    assign bit_mask = WORD_BITS'(1) << idx_reg[BIT_W-1:0];
    assign zero_pos = lowest_zero(rd_word);
    assign scan_pos = {scan_addr_reg, zero_pos};

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.bit_is_set  = rsp_is_set_reg;
    assign rsp.found_index = rsp_found_reg;

    always_comb
    begin
        state_next      = state_reg;
        action_next     = action_reg;
        idx_next        = idx_reg;
        scan_addr_next  = scan_addr_reg;
        word_valid_next = word_valid_reg;
        num_bits_next   = cfg_wr_en ? cfg_wr_data : num_bits_reg;
        res_status_next = res_status_reg;
        res_is_set_next = res_is_set_reg;
        res_found_next  = res_found_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_is_set_next = rsp_is_set_reg;
        rsp_found_next  = rsp_found_reg;
        ram_re          = 1'b0;
        ram_raddr       = '0;
        ram_we          = 1'b0;
        ram_waddr       = look_addr;
        ram_wdata       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    action_next     = req.action;
                    idx_next        = req.bit_index;
                    res_status_next = ST_OK;
                    res_is_set_next = 1'b0;
                    res_found_next  = '0;
                    state_next      = S_DONE;
                    case (req.action)
                        ACT_TEST, ACT_SET, ACT_CLEAR:
                        begin
                            if (req_idx_ok)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = WADDR_W'(req_word_sh);
                                state_next = S_LOOK;
                            end
                            else
                            begin
                                res_status_next = ST_INVALID;
                            end
                        end
                        ACT_FIND:
                        begin
                            if (nwords == '0)
                            begin
                                res_status_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                ram_re         = 1'b1;
                                ram_raddr      = '0;
                                scan_addr_next = '0;
                                state_next     = S_SCAN;
                            end
                        end
                        ACT_CLEAR_ALL:
                        begin
                            word_valid_next = '0;
                        end
                        default:
                        begin
                            res_status_next = ST_INVALID;
                        end
                    endcase
                end
            end

            S_LOOK:
            begin
                state_next = S_DONE;
                case (action_reg)
                    ACT_TEST:
                    begin
                        res_is_set_next = |(rd_word & bit_mask);
                    end
                    ACT_SET:
                    begin
                        ram_we                     = 1'b1;
                        ram_wdata                  = rd_word | bit_mask;
                        word_valid_next[look_addr] = 1'b1;
                    end
                    ACT_CLEAR:
                    begin
                        ram_we                     = 1'b1;
                        ram_wdata                  = rd_word & ~bit_mask;
                        word_valid_next[look_addr] = 1'b1;
                    end
                    default:
                    begin
                        res_status_next = ST_INVALID;
                    end
                endcase
            end

            S_SCAN:
            begin
                if (rd_word != '1)
                begin
                    state_next = S_DONE;
                    if (32'(scan_pos) < 32'(count))
                    begin
                        res_found_next = INDEX_W'(scan_pos);
                    end
                    else
                    begin
                        res_status_next = ST_NOT_FOUND;
                    end
                end
                else if (32'(scan_addr_reg) == 32'(nwords) - 32'd1)
                begin
                    state_next      = S_DONE;
                    res_status_next = ST_NOT_FOUND;
                end
                else
                begin
                    scan_addr_next = scan_addr_reg + WADDR_W'(1);
                    ram_re         = 1'b1;
                    ram_raddr      = scan_addr_reg + WADDR_W'(1);
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_is_set_next = res_is_set_reg;
                    rsp_found_next  = res_found_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            action_reg     <= '0;
            idx_reg        <= '0;
            scan_addr_reg  <= '0;
            word_valid_reg <= '0;
            num_bits_reg   <= NUM_BITS_RESET;
            res_status_reg <= ST_OK;
            res_is_set_reg <= 1'b0;
            res_found_reg  <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_status_reg <= ST_OK;
            rsp_is_set_reg <= 1'b0;
            rsp_found_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            action_reg     <= action_next;
            idx_reg        <= idx_next;
            scan_addr_reg  <= scan_addr_next;
            word_valid_reg <= word_valid_next;
            num_bits_reg   <= num_bits_next;
            res_status_reg <= res_status_next;
            res_is_set_reg <= res_is_set_next;
            res_found_reg  <= res_found_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_status_reg <= rsp_status_next;
            rsp_is_set_reg <= rsp_is_set_next;
            rsp_found_reg  <= rsp_found_next;
        end
    end

    // assertions
    `ASSERT_PROP(a_clear_all_drops_flags, clk, rst_n, (state_reg == S_IDLE && req.valid && req.action == ACT_CLEAR_ALL) |=> (word_valid_reg == '0), "clear-all left a word flagged valid")
    `ASSERT_PROP(a_write_marks_valid, clk, rst_n, ram_we |=> word_valid_reg[$past(ram_waddr)], "written word not flagged valid")
    `ASSERT_PROP(a_is_set_only_on_ok, clk, rst_n, (rsp_valid_reg && rsp_is_set_reg) |-> (rsp_status_reg == ST_OK), "bit_is_set with failing status")
    `ASSERT_PROP(a_scan_in_range, clk, rst_n, (state_reg == S_SCAN) |-> (32'(scan_addr_reg) < NUM_WORDS), "scan address past the last word")

endmodule

/* rtl/bia_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module bia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
